[src/dbb_pkg.sv]
// Package for the dyadic B-spline basis evaluator.
// Holds widths, constants, register codes and the clamped knot function.
// No dependencies.
package dbb_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int MAX_LEVEL  = 5;
    localparam int MAX_DEGREE = 5;
    localparam int ROW_LEN    = MAX_DEGREE + 2;
    localparam int ROW_W      = 18;
    localparam int SAMPLE_W   = 17;
    localparam int INDEX_W    = 6;
    localparam int VALUE_W    = 17;
    localparam int SLOPE_W    = 25;
    localparam int U_W        = 22;
    localparam int DIV_W      = 40;
    localparam int QUO_W      = 27;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [SAMPLE_W-1:0] ONE_Q     = SAMPLE_W'(1) << FRAC_BITS;
    localparam logic [QUO_W-1:0]    SLOPE_MAX = QUO_W'(10485760);
    localparam logic [4:0]          TRI_BITS  = 5'd16;
    localparam logic [4:0]          SLOPE_BITS = 5'd26;

    localparam logic REG_LEVEL  = 1'b0;
    localparam logic REG_DEGREE = 1'b1;

    localparam logic [2:0] LEVEL_RESET  = 3'd2;
    localparam logic [2:0] DEGREE_RESET = 3'd3;

    // Knot k of the clamped vector: k - p limited to the range [0, n].
    function automatic logic [5:0] knot_at(input logic signed [7:0] k,
                                           input logic [2:0] p,
                                           input logic [5:0] n);
        logic signed [7:0] v;
        v = k - $signed({5'b0, p});
        if (v < 0)
            return 6'd0;
        else if (v > $signed({2'b0, n}))
            return n;
        else
            return v[5:0];
    endfunction

endpackage

[src/dbb_if.sv]
// Handshake channels of the dyadic B-spline basis evaluator.
// Depends on dbb_pkg for the field widths.
interface dbb_in_if;
    logic                          valid;
    logic                          ready;
    logic [dbb_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface dbb_out_if;
    logic                                valid;
    logic                                ready;
    logic [dbb_pkg::INDEX_W-1:0]         basis_index;
    logic [dbb_pkg::VALUE_W-1:0]         basis_value;
    logic signed [dbb_pkg::SLOPE_W-1:0]  basis_slope;
    logic                                last;

    modport source (output valid, output basis_index, output basis_value,
                    output basis_slope, output last, input ready);
    modport sink   (input valid, input basis_index, input basis_value,
                    input basis_slope, input last, output ready);
endinterface

[src/dyadic_bspline_basis_eval_top.sv]
// Top level of the dyadic B-spline basis evaluator with first derivative.
// Depends on dbb_pkg and the channel interfaces in dbb_if.
//
// Usage: a sample word (unsigned Q1.16, 65536 is 1.0) enters on in_ch. The
// block then produces 2^level + degree words on out_ch, one per basis index
// in rising order, each with the basis value, its first derivative and a
// last flag on the final word. The level and degree registers are written
// through the APB port; the user must write them only while the block is
// idle; the block does not enforce this. Reset sets level 2, degree 3. One
// sample is processed at a time and in_ch.ready is low until its final word
// has been loaded into the output register. All arithmetic runs through one
// shared restoring divider that resolves one quotient bit per cycle. Each
// Cox-de Boor triangle row starts with a setup step; each update loads the
// divider for 17 quotient bits and writes back. Each output word reads the
// rows, loads the divider for 27 quotient bits and is emitted. When out_ch
// stalls, the block holds its next word and waits; no word is lost. After
// reset the block is idle and ready at once; no memory needs clearing.
module dyadic_bspline_basis_eval_top (
    input  logic                         clk,
    input  logic                         rst_n,
    dbb_in_if.sink                       in_ch,
    dbb_out_if.source                    out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dbb_pkg::ADDR_W-1:0]   paddr,
    input  logic [dbb_pkg::DATA_W-1:0]   pwdata,
    output logic [dbb_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_TRI_ROW,
        S_TRI_MUL,
        S_DIV,
        S_TRI_WR,
        S_OUT_RD1,
        S_OUT_RD2,
        S_OUT_MUL,
        S_OUT_EMIT
    } state_t;

    typedef logic [dbb_pkg::ROW_W-1:0] row_word_t;

    state_t                          state_reg;
    logic [2:0]                      level_reg;
    logic [2:0]                      degree_reg;
    logic [2:0]                      lvl_reg;
    logic [2:0]                      deg_reg;
    logic [dbb_pkg::U_W-1:0]         u_reg;
    logic [4:0]                      seg_reg;
    logic [2:0]                      j_reg;
    logic [2:0]                      r_reg;
    logic [5:0]                      g_reg;
    row_word_t                       carry_reg;
    row_word_t                       nr_reg;
    logic [dbb_pkg::DIV_W-1:0]       rem_reg;
    logic [dbb_pkg::DIV_W-1:0]       dsh_reg;
    logic [dbb_pkg::QUO_W-1:0]       q_reg;
    logic [4:0]                      cnt_reg;
    logic                            tri_reg;
    row_word_t                       work_row_reg [dbb_pkg::ROW_LEN];
    row_word_t                       lower_row_reg [dbb_pkg::ROW_LEN];
    logic [dbb_pkg::VALUE_W-1:0]     val_reg;
    row_word_t                       n1_reg;
    logic [2:0]                      k1_reg;
    logic [2:0]                      k2_reg;
    logic                            k2z_reg;
    logic signed [21:0]              diff_reg;
    logic [4:0]                      den_reg;
    logic                            neg_reg;
    logic                            ov_reg;
    logic [dbb_pkg::INDEX_W-1:0]     out_index_reg;
    logic [dbb_pkg::VALUE_W-1:0]     out_value_reg;
    logic signed [dbb_pkg::SLOPE_W-1:0] out_slope_reg;
    logic                            out_last_reg;

    logic                            cfg_write;
    logic                            in_accept;
    logic [2:0]                      lvl_c;
    logic [2:0]                      deg_c;
    logic [dbb_pkg::SAMPLE_W-1:0]    x_c;
    logic [dbb_pkg::U_W-1:0]         u_c;
    logic [5:0]                      seg_full;
    logic [5:0]                      n_c;
    logic [5:0]                      n_in;
    logic [4:0]                      seg_c;
    logic [5:0]                      count_c;
    logic [7:0]                      pl_c;
    logic [2:0]                      jl;
    logic [2:0]                      jr;
    logic [5:0]                      kl;
    logic [5:0]                      kr;
    logic [dbb_pkg::U_W-1:0]         left_c;
    logic [dbb_pkg::U_W-1:0]         right_c;
    logic [dbb_pkg::U_W:0]           d_c;
    row_word_t                       nr_c;
    logic [dbb_pkg::DIV_W-1:0]       dividend_c;
    logic                            ge_c;
    logic [dbb_pkg::DIV_W-1:0]       rem_step;
    logic [dbb_pkg::QUO_W-1:0]       q_step;
    row_word_t                       a_c;
    row_word_t                       sum_c;
    row_word_t                       rest_c;
    logic                            row_end;
    logic signed [7:0]               rel;
    logic [2:0]                      idx_a;
    logic [2:0]                      idx_b;
    logic                            has_val;
    logic                            has_n1;
    logic                            has_n2;
    logic [5:0]                      k1_c;
    logic [5:0]                      k2_c;
    row_word_t                       n2_c;
    logic signed [30:0]              num_c;
    logic [30:0]                     mag_c;
    logic [dbb_pkg::QUO_W-1:0]       sat_c;
    logic                            can_load;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == dbb_pkg::REG_DEGREE) ? dbb_pkg::DATA_W'(degree_reg)
                                                         : dbb_pkg::DATA_W'(level_reg);

    assign in_ch.ready        = (state_reg == S_IDLE);
    assign in_accept          = in_ch.valid && in_ch.ready;
    assign out_ch.valid       = ov_reg;
    assign out_ch.basis_index = out_index_reg;
    assign out_ch.basis_value = out_value_reg;
    assign out_ch.basis_slope = out_slope_reg;
    assign out_ch.last        = out_last_reg;

    always_comb
    begin
        lvl_c = (level_reg > 3'(dbb_pkg::MAX_LEVEL)) ? 3'(dbb_pkg::MAX_LEVEL) : level_reg;
        if (degree_reg == 3'd0)
            deg_c = 3'd1;
        else if (degree_reg > 3'(dbb_pkg::MAX_DEGREE))
            deg_c = 3'(dbb_pkg::MAX_DEGREE);
        else
            deg_c = degree_reg;
        x_c      = (in_ch.sample > dbb_pkg::ONE_Q) ? dbb_pkg::ONE_Q : in_ch.sample;
        u_c      = dbb_pkg::U_W'(x_c) << lvl_c;
        seg_full = u_c[dbb_pkg::FRAC_BITS +: 6];
        n_in     = 6'd1 << lvl_c;
        seg_c    = (seg_full > n_in - 6'd1) ? 5'(n_in - 6'd1) : seg_full[4:0];
    end

    always_comb
    begin
        n_c     = 6'd1 << lvl_reg;
        count_c = n_c + 6'(deg_reg);
        pl_c    = 8'(deg_reg) << lvl_reg;
        jl      = j_reg - r_reg;
        jr      = r_reg + 3'd1;
        kl      = dbb_pkg::knot_at($signed(8'(seg_reg) + 8'(deg_reg) + 8'd1 - 8'(jl)),
                                   deg_reg, n_c);
        kr      = dbb_pkg::knot_at($signed(8'(seg_reg) + 8'(deg_reg) + 8'(jr)),
                                   deg_reg, n_c);
        left_c  = u_reg - (dbb_pkg::U_W'(kl) << dbb_pkg::FRAC_BITS);
        right_c = (dbb_pkg::U_W'(kr) << dbb_pkg::FRAC_BITS) - u_reg;
        d_c     = {1'b0, left_c} + {1'b0, right_c};
        nr_c    = work_row_reg[r_reg];
        dividend_c = dbb_pkg::DIV_W'(nr_c * right_c) + dbb_pkg::DIV_W'(d_c >> 1);

        ge_c     = (rem_reg >= dsh_reg);
        rem_step = ge_c ? rem_reg - dsh_reg : rem_reg;
        q_step   = {q_reg[dbb_pkg::QUO_W-2:0], ge_c};

        a_c     = (q_reg > dbb_pkg::QUO_W'(nr_reg)) ? nr_reg : q_reg[dbb_pkg::ROW_W-1:0];
        sum_c   = carry_reg + a_c;
        rest_c  = nr_reg - a_c;
        row_end = (r_reg == j_reg - 3'd1);

        rel     = $signed({2'b0, g_reg}) - $signed({3'b0, seg_reg});
        idx_a   = rel[2:0];
        idx_b   = rel[2:0] - 3'd1;
        has_val = (rel >= 0) && (rel <= $signed({5'b0, deg_reg}));
        has_n1  = (rel >= 1) && (rel <= $signed({5'b0, deg_reg}));
        has_n2  = (rel >= 0) && (rel < $signed({5'b0, deg_reg}));
        k1_c    = dbb_pkg::knot_at($signed(8'(g_reg) + 8'(deg_reg)), deg_reg, n_c)
                - dbb_pkg::knot_at($signed(8'(g_reg)), deg_reg, n_c);
        k2_c    = dbb_pkg::knot_at($signed(8'(g_reg) + 8'(deg_reg) + 8'd1), deg_reg, n_c)
                - dbb_pkg::knot_at($signed(8'(g_reg) + 8'd1), deg_reg, n_c);
        n2_c    = (has_n2 && !k2z_reg) ? lower_row_reg[idx_a] : '0;

        num_c   = 31'(diff_reg) * $signed({1'b0, pl_c});
        mag_c   = num_c[30] ? 31'(-num_c) : 31'(num_c);
        sat_c   = (q_reg > dbb_pkg::SLOPE_MAX) ? dbb_pkg::SLOPE_MAX : q_reg;
        can_load = !ov_reg || out_ch.ready;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            work_row_reg[0] <= dbb_pkg::ROW_W'(dbb_pkg::ONE_Q);
        if (state_reg == S_TRI_ROW && j_reg == deg_reg)
            lower_row_reg <= work_row_reg;
        if (state_reg == S_TRI_WR)
        begin
            work_row_reg[r_reg] <= sum_c;
            if (row_end)
                work_row_reg[j_reg] <= rest_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            level_reg  <= dbb_pkg::LEVEL_RESET;
            degree_reg <= dbb_pkg::DEGREE_RESET;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (paddr[2] == dbb_pkg::REG_DEGREE)
                    degree_reg <= pwdata[2:0];
                else
                    level_reg <= pwdata[2:0];
            end
            if (ov_reg && out_ch.ready && !(state_reg == S_OUT_EMIT && can_load))
                ov_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        lvl_reg   <= lvl_c;
                        deg_reg   <= deg_c;
                        u_reg     <= u_c;
                        seg_reg   <= seg_c;
                        j_reg     <= 3'd1;
                        r_reg     <= 3'd0;
                        carry_reg <= '0;
                        state_reg <= S_TRI_ROW;
                    end
                end
                S_TRI_ROW:
                begin
                    state_reg <= S_TRI_MUL;
                end
                S_TRI_MUL:
                begin
                    nr_reg  <= nr_c;
                    q_reg   <= '0;
                    tri_reg <= 1'b1;
                    rem_reg <= dividend_c;
                    dsh_reg <= dbb_pkg::DIV_W'(d_c) << dbb_pkg::TRI_BITS;
                    cnt_reg <= dbb_pkg::TRI_BITS;
                    state_reg <= (d_c == '0) ? S_TRI_WR : S_DIV;
                end
                S_DIV:
                begin
                    rem_reg <= rem_step;
                    q_reg   <= q_step;
                    dsh_reg <= dsh_reg >> 1;
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0)
                        state_reg <= tri_reg ? S_TRI_WR : S_OUT_EMIT;
                end
                S_TRI_WR:
                begin
                    if (row_end)
                    begin
                        carry_reg <= '0;
                        r_reg     <= 3'd0;
                        if (j_reg == deg_reg)
                        begin
                            g_reg     <= '0;
                            state_reg <= S_OUT_RD1;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 3'd1;
                            state_reg <= S_TRI_ROW;
                        end
                    end
                    else
                    begin
                        carry_reg <= rest_c;
                        r_reg     <= r_reg + 3'd1;
                        state_reg <= S_TRI_MUL;
                    end
                end
                S_OUT_RD1:
                begin
                    val_reg <= has_val ? work_row_reg[idx_a][dbb_pkg::VALUE_W-1:0] : '0;
                    n1_reg  <= (has_n1 && k1_c != 6'd0) ? lower_row_reg[idx_b] : '0;
                    k1_reg  <= (k1_c == 6'd0) ? 3'd1 : k1_c[2:0];
                    k2_reg  <= (k2_c == 6'd0) ? 3'd1 : k2_c[2:0];
                    k2z_reg <= (k2_c == 6'd0);
                    state_reg <= S_OUT_RD2;
                end
                S_OUT_RD2:
                begin
                    diff_reg <= $signed(22'(n1_reg * k2_reg)) - $signed(22'(n2_c * k1_reg));
                    den_reg  <= 5'(k1_reg * k2_reg);
                    state_reg <= S_OUT_MUL;
                end
                S_OUT_MUL:
                begin
                    neg_reg <= num_c[30];
                    q_reg   <= '0;
                    tri_reg <= 1'b0;
                    rem_reg <= dbb_pkg::DIV_W'({mag_c[25:0], 1'b0}) + dbb_pkg::DIV_W'(den_reg);
                    dsh_reg <= dbb_pkg::DIV_W'({den_reg, 1'b0}) << dbb_pkg::SLOPE_BITS;
                    cnt_reg <= dbb_pkg::SLOPE_BITS;
                    state_reg <= S_DIV;
                end
                S_OUT_EMIT:
                begin
                    if (can_load)
                    begin
                        ov_reg        <= 1'b1;
                        out_index_reg <= g_reg;
                        out_value_reg <= val_reg;
                        out_slope_reg <= neg_reg ? -$signed(dbb_pkg::SLOPE_W'(sat_c))
                                                 : $signed(dbb_pkg::SLOPE_W'(sat_c));
                        out_last_reg  <= (g_reg == count_c - 6'd1);
                        if (g_reg == count_c - 6'd1)
                            state_reg <= S_IDLE;
                        else
                        begin
                            g_reg     <= g_reg + 6'd1;
                            state_reg <= S_OUT_RD1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The block is not ready in the cycle after it takes a sample.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !in_ch.ready)
        else $error("ready stayed high after a sample was taken");

    // A triangle split never hands on more than the entry it splits.
    a_split_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TRI_WR |-> q_reg <= dbb_pkg::QUO_W'(nr_reg))
        else $error("triangle quotient exceeds the entry being split");

    // While a non-final word is taken, the sample is still being worked on.
    a_not_idle_mid_sample: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.ready && !out_ch.last |-> state_reg != S_IDLE)
        else $error("block idle before the final word of a sample");

endmodule

[verif/dyadic_bspline_basis_eval_top_tb.sv]
// Testbench for the dyadic B-spline basis evaluator top level.
// Drives samples and register writes, and checks every basis word against a built-in predictor.
// Depends on dbb_pkg, the channel interfaces in dbb_if and dyadic_bspline_basis_eval_top.
`timescale 1ns / 100ps

module dyadic_bspline_basis_eval_top_tb;

    localparam int RANDOM_SAMPLES = 450;
    localparam int QUIET_TAIL     = 60;
    localparam int PHASE_LEN      = 30;
    localparam int CYCLE_LIMIT    = 3000000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int HOLD_CYCLES    = 2500;

    localparam int PIN_NONE  = 0;
    localparam int PIN_FIRST = 1;
    localparam int PIN_LAST  = 2;

    typedef struct {
        logic [dbb_pkg::INDEX_W-1:0]        idx;
        logic [dbb_pkg::VALUE_W-1:0]        value;
        logic signed [dbb_pkg::SLOPE_W-1:0] slope;
        logic                               last;
    } basis_word_t;

    typedef struct {
        int lv;
        int dg;
        int x;
        int pin;
        int pin_value;
        int pin_slope;
    } sample_row_t;

    localparam int DIRECTED_ROWS = 20;
    sample_row_t directed [DIRECTED_ROWS] = '{
        '{2, 3, 0,      PIN_FIRST, 65536, -786432},
        '{2, 3, 65536,  PIN_LAST,  65536, 786432},
        '{2, 3, 131071, PIN_LAST,  65536, 786432},
        '{2, 3, 32768,  PIN_NONE,  0, 0},
        '{2, 3, 16384,  PIN_NONE,  0, 0},
        '{2, 3, 1,      PIN_NONE,  0, 0},
        '{2, 3, 65535,  PIN_NONE,  0, 0},
        '{0, 1, 0,      PIN_FIRST, 65536, -65536},
        '{0, 1, 65536,  PIN_LAST,  65536, 65536},
        '{0, 1, 40000,  PIN_NONE,  0, 0},
        '{5, 5, 0,      PIN_FIRST, 65536, -10485760},
        '{5, 5, 65536,  PIN_LAST,  65536, 10485760},
        '{5, 5, 12345,  PIN_NONE,  0, 0},
        '{7, 5, 0,      PIN_FIRST, 65536, -10485760},
        '{1, 0, 0,      PIN_FIRST, 65536, -131072},
        '{3, 7, 65536,  PIN_LAST,  65536, 2621440},
        '{6, 6, 70000,  PIN_LAST,  65536, 10485760},
        '{4, 2, 4096,   PIN_NONE,  0, 0},
        '{4, 4, 65535,  PIN_NONE,  0, 0},
        '{1, 2, 32768,  PIN_NONE,  0, 0}
    };

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [dbb_pkg::ADDR_W-1:0] paddr;
    logic [dbb_pkg::DATA_W-1:0] pwdata;
    logic [dbb_pkg::DATA_W-1:0] prdata;
    logic pready;

    dbb_in_if  in_ch ();
    dbb_out_if out_ch ();

    dyadic_bspline_basis_eval_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    basis_word_t basis_due [$];
    int unsigned cur_level;
    int unsigned cur_degree;
    int fail_count;
    int samples_sent;
    int words_seen;
    int settings_used;
    int hold_left;
    int gap_left;
    bit quiet;
    longint cycles;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint knot_pos(input longint k, input longint p, input longint n);
        longint v;
        v = k - p;
        if (v < 0)
            v = 0;
        if (v > n)
            v = n;
        return v;
    endfunction

    // Runs the Cox-de Boor triangle for one sample and queues every basis word.
    function automatic void predict_basis(input logic [dbb_pkg::SAMPLE_W-1:0] x_in,
                                          input int pin,
                                          input int pin_value, input int pin_slope);
        longint lv, pd, n, seg, s, cnt, xq, ux;
        longint lft [8];
        longint rgt [8];
        longint row [8];
        longint low [8];
        longint carry, d, nr, a, val, n1, n2, k1, k2, num, den, mag, slope;
        basis_word_t w;
        lv = (cur_level > 5) ? 5 : cur_level;
        pd = cur_degree;
        if (pd < 1)
            pd = 1;
        if (pd > 5)
            pd = 5;
        n = longint'(1) << lv;
        xq = x_in;
        if (xq > 65536)
            xq = 65536;
        ux = xq << lv;
        seg = ux >> 16;
        if (seg > n - 1)
            seg = n - 1;
        s = seg + pd;
        for (int j = 0; j < 8; j++)
        begin
            row[j] = 0;
            low[j] = 0;
        end
        for (int j = 1; j <= pd; j++)
        begin
            lft[j] = ux - (knot_pos(s + 1 - j, pd, n) << 16);
            rgt[j] = (knot_pos(s + j, pd, n) << 16) - ux;
        end
        row[0] = 65536;
        for (int j = 1; j <= pd; j++)
        begin
            carry = 0;
            if (j == pd)
                low = row;
            for (int r = 0; r < j; r++)
            begin
                d = rgt[r + 1] + lft[j - r];
                nr = row[r];
                a = 0;
                if (d != 0)
                    a = (nr * rgt[r + 1] + (d >> 1)) / d;
                if (a > nr)
                    a = nr;
                row[r] = (carry + a) & 64'h3FFFF;
                carry = nr - a;
            end
            row[j] = carry & 64'h3FFFF;
        end
        cnt = n + pd;
        for (longint g = 0; g < cnt; g++)
        begin
            val = 0;
            n1 = 0;
            n2 = 0;
            if (g >= s - pd && g <= s)
                val = row[g - (s - pd)];
            if (g >= s - pd + 1 && g <= s)
                n1 = low[g - (s - pd + 1)];
            if (g + 1 >= s - pd + 1 && g + 1 <= s)
                n2 = low[g + 1 - (s - pd + 1)];
            k1 = knot_pos(g + pd, pd, n) - knot_pos(g, pd, n);
            k2 = knot_pos(g + pd + 1, pd, n) - knot_pos(g + 1, pd, n);
            if (k1 == 0)
            begin
                n1 = 0;
                k1 = 1;
            end
            if (k2 == 0)
            begin
                n2 = 0;
                k2 = 1;
            end
            num = (pd << lv) * (n1 * k2 - n2 * k1);
            den = k1 * k2;
            mag = (num < 0) ? -num : num;
            mag = (2 * mag + den) / (2 * den);
            if (mag > 10485760)
                mag = 10485760;
            slope = (num < 0) ? -mag : mag;
            w.idx = g[dbb_pkg::INDEX_W-1:0];
            w.value = val[dbb_pkg::VALUE_W-1:0];
            w.slope = slope[dbb_pkg::SLOPE_W-1:0];
            w.last = (g == cnt - 1);
            if ((pin == PIN_FIRST && g == 0) || (pin == PIN_LAST && g == cnt - 1))
            begin
                w.value = pin_value[dbb_pkg::VALUE_W-1:0];
                w.slope = pin_slope[dbb_pkg::SLOPE_W-1:0];
            end
            basis_due.push_back(w);
        end
    endfunction

    task automatic send_sample(input logic [dbb_pkg::SAMPLE_W-1:0] x, input int pin,
                               input int pin_value, input int pin_slope);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.sample <= x;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_basis(x, pin, pin_value, pin_slope);
        samples_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (basis_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic reg_code, input int unsigned v);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= dbb_pkg::ADDR_W'(reg_code) << 2;
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_code == dbb_pkg::REG_LEVEL)
            cur_level = v & 7;
        else
            cur_degree = v & 7;
    endtask

    task automatic set_config(input int unsigned lv, input int unsigned dg);
        if (lv == cur_level && dg == cur_degree)
            return;
        wait_idle();
        if (lv != cur_level)
            write_reg(dbb_pkg::REG_LEVEL, lv);
        if (dg != cur_degree)
            write_reg(dbb_pkg::REG_DEGREE, dg);
        settings_used++;
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end
        else if (gap_left > 0)
        begin
            out_ch.ready <= 1'b0;
            gap_left--;
        end
        else if (rst_n && !quiet && $urandom_range(0, 9) == 0)
        begin
            out_ch.ready <= 1'b0;
            gap_left = $urandom_range(1, 9) - 1;
        end
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        basis_word_t w;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            words_seen++;
            if (basis_due.size() == 0)
            begin
                $error("Word with index %0d arrived with none expected", out_ch.basis_index);
                fail_count++;
            end
            else
            begin
                w = basis_due.pop_front();
                if (out_ch.basis_index !== w.idx)
                begin
                    $error("basis_index: expected %0d, got %0d", w.idx, out_ch.basis_index);
                    fail_count++;
                end
                if (out_ch.basis_value !== w.value)
                begin
                    $error("basis_value: expected %0d, got %0d", w.value, out_ch.basis_value);
                    fail_count++;
                end
                if (out_ch.basis_slope !== w.slope)
                begin
                    $error("basis_slope: expected %0d, got %0d", w.slope, out_ch.basis_slope);
                    fail_count++;
                end
                if (out_ch.last !== w.last)
                begin
                    $error("last: expected %0d, got %0d", w.last, out_ch.last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timed out with %0d words still expected.", basis_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int unsigned x;
        int unsigned lv;
        int unsigned dg;
        int pick;
        fail_count = 0;
        samples_sent = 0;
        words_seen = 0;
        settings_used = 1;
        hold_left = 0;
        gap_left = 0;
        quiet = 1'b0;
        cycles = 0;
        cur_level = dbb_pkg::LEVEL_RESET;
        cur_degree = dbb_pkg::DEGREE_RESET;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.sample = '0;
        out_ch.ready = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            set_config(directed[i].lv, directed[i].dg);
            send_sample(directed[i].x, directed[i].pin, directed[i].pin_value,
                        directed[i].pin_slope);
        end

        for (int k = 0; k < RANDOM_SAMPLES; k++)
        begin
            if (k % PHASE_LEN == 0)
            begin
                lv = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(4, 7);
                dg = $urandom_range(0, 7);
                set_config(lv, dg);
                quiet = (k >= RANDOM_SAMPLES - QUIET_TAIL) || ($urandom_range(0, 5) == 0);
            end
            if (k == 100)
                hold_left = HOLD_CYCLES;
            pick = $urandom_range(0, 7);
            lv = (cur_level > 5) ? 5 : cur_level;
            if (pick == 0)
                x = $urandom_range(0, 131071);
            else if (pick == 1)
                x = $urandom_range(0, 1 << lv) << (16 - lv);
            else
                x = $urandom_range(0, 65536);
            send_sample(x, PIN_NONE, 0, 0);
        end

        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (basis_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (basis_due.size() != 0)
        begin
            $error("%0d expected words never arrived", basis_due.size());
            fail_count++;
        end
        $display("Sent %0d samples over %0d register settings and checked %0d basis words.",
                 samples_sent, settings_used, words_seen);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
src/dbb_pkg.sv
src/dbb_if.sv
src/dyadic_bspline_basis_eval_top.sv
verif/dyadic_bspline_basis_eval_top_tb.sv
